// ===== design/crast_pkg.sv =====
// ----------------------------------------------------------------------------
// crast_pkg
// Shared types and constants of the filled circle rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package crast_pkg;

    localparam int COORD_W    = 9;
    localparam int FRAME_SIZE = 1 << COORD_W;
    localparam int RADIUS_W   = 8;
    localparam int DEC_W      = 12;
    localparam int COLOR_W    = 32;
    localparam int KIND_W     = 2;
    localparam int SLOT_W     = 3;
    localparam int NUM_SLOTS  = 6;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COLOR_W-1:0] OUTLINE_COLOR_RESET = 32'hffff_ffff;
    localparam logic [COLOR_W-1:0] FILL_COLOR_RESET    = 32'hff00_00ff;

    // configuration register indexes
    typedef enum logic
    {
        REG_OUTLINE_COLOR = 1'b0,
        REG_FILL_COLOR    = 1'b1
    } reg_index_t;

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    typedef enum logic [KIND_W-1:0]
    {
        KIND_PIXEL = 2'd0,
        KIND_SPAN  = 2'd1,
        KIND_IDLE  = 2'd2
    } kind_t;

    typedef enum logic [1:0]
    {
        PH_IDLE         = 2'd0,
        PH_SWEEP1       = 2'd1,
        PH_SWEEP2_START = 2'd2,
        PH_SWEEP2       = 2'd3
    } phase_t;

    typedef enum logic [2:0]
    {
        MODE_START,
        MODE_SWEEP1,
        MODE_SWEEP2_START,
        MODE_SWEEP2,
        MODE_IDLE
    } mode_t;

    typedef struct packed
    {
        logic                op;
        logic [COORD_W-1:0]  center_a;
        logic [COORD_W-1:0]  center_b;
        logic [RADIUS_W-1:0] radius;
    } cmd_t;

    typedef struct packed
    {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] coord_a;
        logic [COORD_W-1:0] first_b;
        logic [COORD_W-1:0] last_b;
        logic [COLOR_W-1:0] color;
        logic               last;
        logic               circle_done;
    } wr_t;

    // one classified command, waiting for the back end
    typedef struct packed
    {
        mode_t              mode;
        logic [COORD_W-1:0] center_a;
        logic [COORD_W-1:0] center_b;
        logic [COORD_W-1:0] major;
        logic [COORD_W-1:0] minor;
        logic               done;
    } q_entry_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// ===== design/crast_ifs.sv =====
// ----------------------------------------------------------------------------
// crast_ifs
// Valid/ready channels for commands and framebuffer write records.
// ----------------------------------------------------------------------------
`default_nettype none

interface crast_cmd_if;
    logic             valid;
    logic             ready;
    crast_pkg::cmd_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface crast_wr_if;
    logic             valid;
    logic             ready;
    crast_pkg::wr_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/crast_front.sv =====
// ----------------------------------------------------------------------------
// crast_front
// Accept commands, advance the midpoint sweeps and queue one entry per command.
// ----------------------------------------------------------------------------
`default_nettype none

module crast_front
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    crast_cmd_if.sink                 cmd,
    input  wire crast_pkg::q_status_t q_status,
    output logic                      push,
    output crast_pkg::q_entry_t       entry
);
    import crast_pkg::*;

    phase_t                     phase_reg, phase_next;
    logic [COORD_W-1:0]         center_a_reg, center_a_next;
    logic [COORD_W-1:0]         center_b_reg, center_b_next;
    logic [COORD_W-1:0]         major_reg, major_next;
    logic [COORD_W-1:0]         minor_reg, minor_next;
    logic signed [DEC_W-1:0]    decision_reg, decision_next;
    logic [RADIUS_W-1:0]        radius_reg, radius_next;

    logic signed [DEC_W-1:0]    major_ext, minor_ext, start_dec;
    logic [RADIUS_W-1:0]        start_radius;
    mode_t                      mode;

    assign cmd.ready = !q_status.full;
    assign push      = cmd.valid && cmd.ready;

    assign major_ext = $signed({{(DEC_W-COORD_W){1'b0}}, major_reg});
    assign minor_ext = $signed({{(DEC_W-COORD_W){1'b0}}, minor_reg});

    // radius used for a fresh decision value: the new one on start, else the held one
    assign start_radius = (cmd.data.op == OP_START) ? cmd.data.radius : radius_reg;
    assign start_dec    = $signed(DEC_W'(3))
                        - $signed({{(DEC_W-RADIUS_W-1){1'b0}}, start_radius, 1'b0});

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        center_a_next = center_a_reg;
        center_b_next = center_b_reg;
        major_next    = major_reg;
        minor_next    = minor_reg;
        decision_next = decision_reg;
        radius_next   = radius_reg;
        mode          = MODE_IDLE;
        if (cmd.data.op == OP_START)
        begin
            mode          = MODE_START;
            center_a_next = cmd.data.center_a;
            center_b_next = cmd.data.center_b;
            radius_next   = cmd.data.radius;
            major_next    = '0;
            minor_next    = COORD_W'(cmd.data.radius);
            decision_next = start_dec;
            phase_next    = (cmd.data.radius != '0) ? PH_SWEEP1 : PH_SWEEP2_START;
        end
        else
        begin
            priority if (phase_reg == PH_SWEEP1 && major_reg < minor_reg)
            begin
                mode = MODE_SWEEP1;
                if (decision_reg[DEC_W-1])
                begin
                    decision_next = decision_reg + (major_ext <<< 2) + DEC_W'(6);
                    minor_next    = minor_reg;
                end
                else
                begin
                    decision_next = decision_reg + ((major_ext - minor_ext) <<< 2)
                                  + DEC_W'(10);
                    minor_next    = minor_reg - 1'b1;
                end
                major_next = major_reg + 1'b1;
                if (!(major_next < minor_next))
                begin
                    phase_next = PH_SWEEP2_START;
                end
            end
            else if (phase_reg == PH_SWEEP2_START)
            begin
                mode          = MODE_SWEEP2_START;
                major_next    = COORD_W'(radius_reg);
                minor_next    = '0;
                decision_next = start_dec;
                phase_next    = (radius_reg != '0) ? PH_SWEEP2 : PH_IDLE;
            end
            else if (phase_reg == PH_SWEEP2 && major_reg > minor_reg)
            begin
                mode = MODE_SWEEP2;
                if (decision_reg[DEC_W-1])
                begin
                    decision_next = decision_reg + (minor_ext <<< 2) + DEC_W'(6);
                    major_next    = major_reg;
                end
                else
                begin
                    decision_next = decision_reg + ((minor_ext - major_ext) <<< 2)
                                  + DEC_W'(10);
                    major_next    = major_reg - 1'b1;
                end
                minor_next = minor_reg + 1'b1;
                if (!(major_next > minor_next))
                begin
                    phase_next = PH_IDLE;
                end
            end
            else
            begin
                mode       = MODE_IDLE;
                phase_next = PH_IDLE;
            end
        end
    end

    // queue entry
    always_comb
    begin
        entry.mode     = mode;
        entry.center_a = center_a_next;
        entry.center_b = center_b_next;
        entry.major    = major_next;
        entry.minor    = minor_next;
        entry.done     = (phase_next == PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            center_a_reg <= '0;
            center_b_reg <= '0;
            major_reg    <= '0;
            minor_reg    <= '0;
            decision_reg <= '0;
            radius_reg   <= '0;
        end
        else if (push)
        begin
            phase_reg    <= phase_next;
            center_a_reg <= center_a_next;
            center_b_reg <= center_b_next;
            major_reg    <= major_next;
            minor_reg    <= minor_next;
            decision_reg <= decision_next;
            radius_reg   <= radius_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/crast_queue.sv =====
// ----------------------------------------------------------------------------
// crast_queue
// Short FIFO of classified commands between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module crast_queue
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire crast_pkg::q_entry_t  push_entry,
    input  wire logic                 pop,
    output crast_pkg::q_entry_t       head,
    output crast_pkg::q_status_t      status
);
    import crast_pkg::*;

    q_entry_t            slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/crast_back.sv =====
// ----------------------------------------------------------------------------
// crast_back
// Expand the head command into write records, one per cycle while the write
// channel is ready, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crast_back
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire crast_pkg::q_entry_t               head,
    input  wire crast_pkg::q_status_t              q_status,
    input  wire logic [crast_pkg::COLOR_W-1:0]     outline_color,
    input  wire logic [crast_pkg::COLOR_W-1:0]     fill_color,
    output logic                                   pop,
    crast_wr_if.source                             wr
);
    import crast_pkg::*;

    typedef enum logic [1:0]
    {
        ROW_CENTER,
        ROW_PLUS,
        ROW_MINUS
    } row_sel_t;

    typedef enum logic [1:0]
    {
        COL_CENTER,
        COL_PLUS,
        COL_MINUS,
        COL_SPAN
    } col_sel_t;

    typedef struct packed
    {
        logic     present;
        kind_t    kind;
        row_sel_t row;
        col_sel_t col;
        logic     fill;
    } slot_t;

    function automatic slot_t slot_info(mode_t mode, logic [SLOT_W-1:0] slot,
                                        logic has_span);
        slot_t s;
        s = '{present: 1'b0, kind: KIND_PIXEL, row: ROW_CENTER, col: COL_CENTER,
              fill: 1'b0};
        unique case (mode)
            MODE_START:
            begin
                s.present = (slot < SLOT_W'(3)) || (slot == SLOT_W'(3) && has_span);
                if (slot == SLOT_W'(0))
                begin
                    s.fill = 1'b1;
                end
                else if (slot == SLOT_W'(1))
                begin
                    s.col = COL_PLUS;
                end
                else if (slot == SLOT_W'(2))
                begin
                    s.col = COL_MINUS;
                end
                else
                begin
                    s.kind = KIND_SPAN;
                    s.col  = COL_SPAN;
                    s.fill = 1'b1;
                end
            end
            MODE_SWEEP1:
            begin
                // plus row: pixel, pixel, span; then the same on the minus row
                s.row = (slot < SLOT_W'(3)) ? ROW_PLUS : ROW_MINUS;
                if (slot == SLOT_W'(2) || slot == SLOT_W'(5))
                begin
                    s.present = has_span;
                    s.kind    = KIND_SPAN;
                    s.col     = COL_SPAN;
                    s.fill    = 1'b1;
                end
                else
                begin
                    s.present = (slot < SLOT_W'(NUM_SLOTS));
                    s.col     = (slot == SLOT_W'(0) || slot == SLOT_W'(3)) ? COL_PLUS
                                                                           : COL_MINUS;
                end
            end
            MODE_SWEEP2_START:
            begin
                s.present = (slot < SLOT_W'(2));
                s.row     = (slot == SLOT_W'(0)) ? ROW_PLUS : ROW_MINUS;
            end
            MODE_SWEEP2:
            begin
                // four mirrored pixels, then both spans
                if (slot < SLOT_W'(4))
                begin
                    s.present = 1'b1;
                    s.row     = (slot < SLOT_W'(2)) ? ROW_PLUS : ROW_MINUS;
                    s.col     = slot[0] ? COL_MINUS : COL_PLUS;
                end
                else
                begin
                    s.present = has_span && (slot < SLOT_W'(NUM_SLOTS));
                    s.kind    = KIND_SPAN;
                    s.row     = (slot == SLOT_W'(4)) ? ROW_PLUS : ROW_MINUS;
                    s.col     = COL_SPAN;
                    s.fill    = 1'b1;
                end
            end
            default:
            begin
                s.present = (slot == SLOT_W'(0));
                s.kind    = KIND_IDLE;
            end
        endcase
        return s;
    endfunction

    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               valid_reg;
    wr_t                data_reg, data_next;
    logic               advance, emit, has_next;
    logic               has_span;
    slot_t              cur;
    logic [COORD_W-1:0] row_val, first_val, last_val;
    slot_t              probe;

    assign advance  = !valid_reg || wr.ready;
    assign emit     = advance && !q_status.empty;
    assign has_span = (head.minor != '0);
    assign cur      = slot_info(head.mode, slot_reg, has_span);

    // find the next present slot after the current one
    always_comb
    begin
        has_next  = 1'b0;
        slot_next = '0;
        probe     = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            probe = slot_info(head.mode, SLOT_W'(i), has_span);
            if (!has_next && SLOT_W'(i) > slot_reg && probe.present)
            begin
                has_next  = 1'b1;
                slot_next = SLOT_W'(i);
            end
        end
    end

    assign pop = emit && !has_next;

    always_comb
    begin
        unique case (cur.row)
            ROW_PLUS:  row_val = head.center_a + head.major;
            ROW_MINUS: row_val = head.center_a - head.major;
            default:   row_val = head.center_a;
        endcase
        unique case (cur.col)
            COL_PLUS:
            begin
                first_val = head.center_b + head.minor;
                last_val  = first_val;
            end
            COL_MINUS:
            begin
                first_val = head.center_b - head.minor;
                last_val  = first_val;
            end
            COL_SPAN:
            begin
                first_val = head.center_b - head.minor + 1'b1;
                last_val  = head.center_b + head.minor - 1'b1;
            end
            default:
            begin
                first_val = head.center_b;
                last_val  = head.center_b;
            end
        endcase

        data_next.kind        = cur.kind;
        data_next.coord_a     = row_val;
        data_next.first_b     = first_val;
        data_next.last_b      = last_val;
        data_next.color       = cur.fill ? fill_color : outline_color;
        data_next.last        = !has_next;
        data_next.circle_done = head.done;
        if (cur.kind == KIND_IDLE)
        begin
            data_next.coord_a = '0;
            data_next.first_b = '0;
            data_next.last_b  = '0;
            data_next.color   = '0;
        end
    end

    assign wr.valid = valid_reg;
    assign wr.data  = data_reg;

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            data_reg <= data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            slot_reg  <= '0;
        end
        else if (advance)
        begin
            valid_reg <= !q_status.empty;
            if (emit)
            begin
                slot_reg <= has_next ? slot_next : '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/filled_circle_rasterizer.sv =====
// ----------------------------------------------------------------------------
// filled_circle_rasterizer
// Midpoint circle engine: start/step commands in, pixel and span writes out.
// ----------------------------------------------------------------------------
// A start command (op 0) latches centre and radius and yields the centre
// pixel, the two outline points on the centre row and the first fill span.
// Each step command (op 1) advances one iteration of the current sweep and
// yields up to six records: mirrored outline pixels and horizontal fill
// spans; the step that opens the second sweep yields two pixels, and a step
// with no work left yields a single idle record. Every record carries last on
// the final record of its command and circle_done once both sweeps are over.
// The front end updates the sweep state and classifies the command in the
// cycle it is accepted, so commands may arrive back to back; a two-entry
// queue holds them until the back end has loaded their records. The back
// end sends one record per cycle through an output register while the
// write channel is ready; a command yields 1 to 6 records (6 for a full
// sweep step), and the command channel stalls only while the queue is full.
// Coordinates wrap at the frame size. Colors come from the two configuration
// registers, which must be written only while no command is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module filled_circle_rasterizer
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    crast_cmd_if.sink                          cmd,
    crast_wr_if.source                         wr,
    input  wire logic                          cfg_we,
    input  wire crast_pkg::reg_index_t         cfg_index,
    input  wire logic [crast_pkg::COLOR_W-1:0] cfg_data
);
    import crast_pkg::*;

    logic [COLOR_W-1:0] outline_color_reg;
    logic [COLOR_W-1:0] fill_color_reg;

    logic               push;
    logic               pop;
    q_entry_t           push_entry;
    q_entry_t           head;
    q_status_t          q_status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outline_color_reg <= OUTLINE_COLOR_RESET;
            fill_color_reg    <= FILL_COLOR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OUTLINE_COLOR: outline_color_reg <= cfg_data;
                REG_FILL_COLOR:    fill_color_reg    <= cfg_data;
                default:           outline_color_reg <= outline_color_reg;
            endcase
        end
    end

    // classify commands and advance the sweep state
    crast_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .q_status (q_status),
        .push     (push),
        .entry    (push_entry)
    );

    // hold classified commands between the two halves
    crast_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // expand each command into its write records
    crast_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_status      (q_status),
        .outline_color (outline_color_reg),
        .fill_color    (fill_color_reg),
        .pop           (pop),
        .wr            (wr)
    );

    // an idle record is always the sole record of its command, with nothing left
    assert property (@(posedge clk) disable iff (!rst_n)
        wr.valid && wr.data.kind == KIND_IDLE |-> wr.data.last && wr.data.circle_done)
        else $error("idle record without last or circle_done");

    // spans are drawn in the fill color
    assert property (@(posedge clk) disable iff (!rst_n)
        wr.valid && wr.data.kind == KIND_SPAN |-> wr.data.color == fill_color_reg)
        else $error("span record not in fill color");

    // a single pixel covers exactly one column
    assert property (@(posedge clk) disable iff (!rst_n)
        wr.valid && wr.data.kind == KIND_PIXEL |-> wr.data.first_b == wr.data.last_b)
        else $error("pixel record spans more than one column");

    // the queue pops a command only while its last record is loaded for output
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> wr.valid)
        else $error("command retired without an output record");

endmodule

`default_nettype wire
